@@ rtl/prk_pkg.sv @@
// ----------------------------------------------------------------------------
// Permutation rank package
// Shared widths, the rank modulus and the sequencer state encoding.
// ----------------------------------------------------------------------------
package prk_pkg;

  // value space and field widths
  localparam int MaxLength = 256;
  localparam int IdxW      = $clog2(MaxLength);
  localparam int LenW      = IdxW + 1;
  localparam int RankW     = 30;

  // modulus, kept at 32 bits so 2*p fits
  localparam int RedW = RankW + 2;
  localparam logic [RedW-1:0] RankPrime  = RedW'(998244353);
  localparam logic [RedW-1:0] RankPrime2 = RedW'(2 * 998244353);

  // seen-flag scan: one chunk of flags per cycle
  localparam int ChunkW    = 32;
  localparam int NumChunks = MaxLength / ChunkW;
  localparam int ChunkIdxW = $clog2(NumChunks);
  localparam int CntW      = $clog2(ChunkW + 1);

  // run phase covers both the multiplier bits and the flag chunks
  localparam int RunSteps = (LenW > NumChunks) ? LenW : NumChunks;
  localparam int StepW    = $clog2(RunSteps);

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FOLD = 3'b100
  } state_e;

endpackage

@@ rtl/permutation_rank_mod_prime.sv @@
// ----------------------------------------------------------------------------
// Permutation rank modulo 998244353
// Takes the elements of a permutation one word at a time, forms each Lehmer
// digit by scanning the seen flags, and folds it into the rank by Horner steps.
// ----------------------------------------------------------------------------
// Per element word: accept in S_IDLE, run steps set by the bit-serial modular
//   multiplier over the 9-bit factor, then fold; no new word until idle again.
// The result is registered at the last word's fold, held while output is busy.
// The 256 seen flags are scanned 32 per cycle alongside the multiplier.
// Reset (rst_ni low, asynchronous): length 1, flags, rank, position and error
//   cleared, no result pending. A length write also starts a new permutation.
module permutation_rank_mod_prime
  import prk_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [LenW-1:0]  cfg_wdata_i,
  // element words
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [IdxW-1:0]  element_value_i,
  // result words
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [RankW-1:0] rank_mod_o,
  output logic             bad_input_o
);

  state_e               state_q, state_d;
  logic [LenW-1:0]      len_q;
  logic [LenW-1:0]      n_eff;
  logic [MaxLength-1:0] seen_q;
  logic [RankW-1:0]     acc_q, acc_d;
  logic [LenW-1:0]      pos_q, pos_next;
  logic                 err_q;
  logic [IdxW-1:0]      val_q;
  logic                 skip_q;        // out of range or repeated
  logic [LenW-1:0]      mul_q;         // factor n - i, shifted MSB first
  logic [RankW-1:0]     prod_q;        // running acc * factor mod p
  logic [LenW-1:0]      below_q;       // seen values below val_q
  logic [StepW-1:0]     step_q;
  logic                 out_valid_q;
  logic [RankW-1:0]     out_rank_q;
  logic                 out_bad_q;

  logic                 accept;
  logic                 in_skip;
  logic                 last_step;
  logic                 done;
  logic                 fold_go;
  logic                 out_free;
  logic [RedW-1:0]      dbl_sum;
  logic [RedW-1:0]      dbl_red;
  logic [ChunkIdxW-1:0] chunk_idx;
  logic [ChunkW-1:0]    chunk_bits;
  logic [ChunkW-1:0]    chunk_mask;
  logic [CntW-1:0]      chunk_cnt;
  logic [IdxW-1:0]      digit;
  logic [RedW-1:0]      fold_sum;

  // clamp the programmed length to 1..MaxLength
  always_comb begin
    if (len_q == '0) begin
      n_eff = LenW'(1);
    end else if (len_q > LenW'(MaxLength)) begin
      n_eff = LenW'(MaxLength);
    end else begin
      n_eff = len_q;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_skip    = ({1'b0, element_value_i} >= n_eff) || seen_q[element_value_i];
  assign last_step  = (step_q == StepW'(RunSteps - 1));

  // modular double-and-add step: r = 2r + bit*acc, reduced below p
  always_comb begin
    dbl_sum = {1'b0, prod_q, 1'b0} + (mul_q[LenW-1] ? RedW'(acc_q) : '0);
    if (dbl_sum >= RankPrime2) begin
      dbl_red = dbl_sum - RankPrime2;
    end else if (dbl_sum >= RankPrime) begin
      dbl_red = dbl_sum - RankPrime;
    end else begin
      dbl_red = dbl_sum;
    end
  end

  // count seen flags below val_q in the current chunk
  assign chunk_idx  = step_q[ChunkIdxW-1:0];
  assign chunk_bits = seen_q[chunk_idx*ChunkW +: ChunkW];

  always_comb begin
    if (chunk_idx < val_q[IdxW-1 -: ChunkIdxW]) begin
      chunk_mask = '1;
    end else if (chunk_idx == val_q[IdxW-1 -: ChunkIdxW]) begin
      chunk_mask = ~({ChunkW{1'b1}} << val_q[IdxW-ChunkIdxW-1:0]);
    end else begin
      chunk_mask = '0;
    end
  end

  always_comb begin
    chunk_cnt = '0;
    for (int j = 0; j < ChunkW; j++) begin
      chunk_cnt = chunk_cnt + CntW'(chunk_bits[j] & chunk_mask[j]);
    end
  end

  // fold the digit into the product
  assign digit    = skip_q ? '0 : (val_q - below_q[IdxW-1:0]);
  assign fold_sum = RedW'(prod_q) + RedW'(digit);
  assign acc_d    = (fold_sum >= RankPrime) ? RankW'(fold_sum - RankPrime)
                                            : fold_sum[RankW-1:0];
  assign pos_next = pos_q + LenW'(1);
  assign done     = (pos_next >= n_eff);
  assign out_free = !out_valid_q || out_ready_i;
  assign fold_go  = (state_q == S_FOLD) && (!done || out_free);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_RUN;
      end
      S_RUN: begin
        if (last_step) state_d = S_FOLD;
      end
      S_FOLD: begin
        if (fold_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // per-permutation state: length, flags, rank, position, error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LenW'(1);
      seen_q <= '0;
      acc_q  <= '0;
      pos_q  <= '0;
      err_q  <= 1'b0;
    end else if (cfg_we_i) begin
      len_q  <= cfg_wdata_i;
      seen_q <= '0;
      acc_q  <= '0;
      pos_q  <= '0;
      err_q  <= 1'b0;
    end else if (fold_go) begin
      if (done) begin
        seen_q <= '0;
        acc_q  <= '0;
        pos_q  <= '0;
        err_q  <= 1'b0;
      end else begin
        if (!skip_q) seen_q[val_q] <= 1'b1;
        acc_q <= acc_d;
        pos_q <= pos_next;
        err_q <= err_q | skip_q;
      end
    end
  end

  // working registers of the current element
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (accept) begin
      step_q <= '0;
    end else if (state_q == S_RUN) begin
      step_q <= step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q   <= element_value_i;
      skip_q  <= in_skip;
      mul_q   <= n_eff - pos_q;
      prod_q  <= '0;
      below_q <= '0;
    end else if (state_q == S_RUN) begin
      if (step_q >= StepW'(RunSteps - LenW)) begin
        prod_q <= dbl_red[RankW-1:0];
        mul_q  <= mul_q << 1;
      end
      if (step_q < StepW'(NumChunks)) begin
        below_q <= below_q + LenW'(chunk_cnt);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fold_go && done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fold_go && done) begin
      out_rank_q <= acc_d;
      out_bad_q  <= err_q | skip_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rank_mod_o  = out_rank_q;
  assign bad_input_o = out_bad_q;

  // checks
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (pos_q < n_eff))
    else $error("position count reached the length while idle");

  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    RedW'(acc_q) < RankPrime)
    else $error("rank accumulator not reduced");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RUN) && (step_q == '0))
    else $error("accepted word did not start a run");

endmodule
